// ===== rtl/core/aee_pkg.sv =====
package aee_pkg;

  localparam int MAX_ENTRIES_DEF = 1024;

  localparam int INDEX_W  = 10;
  localparam int TIME_W   = 32;
  localparam int COUNT_W  = 11;
  localparam int STATUS_W = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_ENTRY_COUNT    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_IDLE       = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SWEEP_INTERVAL = 2'd2;

  localparam logic [COUNT_W-1:0] ENTRY_COUNT_RST    = 11'd0;
  localparam logic [TIME_W-1:0]  MAX_IDLE_RST       = 32'd300000;
  localparam logic [TIME_W-1:0]  SWEEP_INTERVAL_RST = 32'd10000;

  localparam logic [STATUS_W-1:0] STATUS_HIT    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_REJECT = 2'd2;

  typedef struct packed {
    logic              resident;
    logic [TIME_W-1:0] stamp;
  } entry_t;

endpackage

// ===== rtl/core/age_based_entry_eviction_unit.sv =====
// flow: a rejected request goes straight to emit; an accepted request sweeps the first
// limit entries when a sweep is due (limit = entry count capped at MAX_ENTRIES), then
// reads and stamps its entry and emits; throughput: one request at a time, the sweep
// walking the entry memory one entry per cycle through its single read port
// reset: synchronous active-low; registers take their reset values, then a clearing
// pass zeroes all MAX_ENTRIES entries before the first request is taken
module age_based_entry_eviction_unit #(
  parameter int MAX_ENTRIES = aee_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [aee_pkg::INDEX_W-1:0]    in_entry_index,
  input  logic [aee_pkg::TIME_W-1:0]     in_now_ms,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [aee_pkg::STATUS_W-1:0]   out_status,
  output logic                           out_swept,
  output logic [aee_pkg::COUNT_W-1:0]    out_evicted_count,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [aee_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aee_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int LIM_W = (IDX_W + 1 > aee_pkg::COUNT_W) ? IDX_W + 1 : aee_pkg::COUNT_W;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SWEEP,
    ST_SWEEP_END,
    ST_ACC_RD,
    ST_ACC_WR,
    ST_EMIT
  } state_t;

  state_t state_r;

  logic [aee_pkg::COUNT_W-1:0]  entry_count_r;
  logic [aee_pkg::TIME_W-1:0]   max_idle_r;
  logic [aee_pkg::TIME_W-1:0]   sweep_interval_r;
  logic [aee_pkg::TIME_W-1:0]   last_sweep_r;

  logic [aee_pkg::INDEX_W-1:0]  idx_r;
  logic [aee_pkg::TIME_W-1:0]   now_r;
  logic [IDX_W-1:0]             ptr_r;
  logic [IDX_W-1:0]             rd_addr_r;
  logic                         rd_vld_r;

  logic [aee_pkg::STATUS_W-1:0] status_r;
  logic                         swept_r;
  logic [aee_pkg::COUNT_W-1:0]  cnt_r;

  logic                         out_valid_r;
  logic [aee_pkg::STATUS_W-1:0] out_status_r;
  logic                         out_swept_r;
  logic [aee_pkg::COUNT_W-1:0]  out_cnt_r;

  aee_pkg::entry_t mem [MAX_ENTRIES];
  aee_pkg::entry_t mem_rdata_r;
  aee_pkg::entry_t mem_wdata;
  logic [IDX_W-1:0] mem_waddr;
  logic [IDX_W-1:0] mem_raddr;
  logic             mem_we;

  logic [LIM_W-1:0] lim;
  logic [LIM_W-1:0] idx_ext;
  logic [LIM_W-1:0] acc_idx_ext;
  logic [IDX_W-1:0] acc_addr;
  logic             in_acc;
  logic             reject;
  logic             due;
  logic             evict;
  logic             out_free;

  // active entry count, capped at the table depth
  assign lim = (LIM_W'(entry_count_r) > LIM_W'(MAX_ENTRIES)) ?
               LIM_W'(MAX_ENTRIES) : LIM_W'(entry_count_r);

  assign idx_ext     = LIM_W'(in_entry_index);
  assign acc_idx_ext = LIM_W'(idx_r);
  assign acc_addr    = acc_idx_ext[IDX_W-1:0];

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign reject   = (idx_ext >= lim);
  assign due      = ((in_now_ms - last_sweep_r) > sweep_interval_r);
  assign evict    = rd_vld_r && mem_rdata_r.resident &&
                    ((now_r - mem_rdata_r.stamp) > max_idle_r);
  assign out_free = !out_valid_r || !out_stall;

  assign cfg_ready         = 1'b1;
  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_swept         = out_swept_r;
  assign out_evicted_count = out_cnt_r;

  // write port: clearing pass, eviction, access stamp
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = ptr_r;
    mem_wdata = '{resident: 1'b0, stamp: '0};
    mem_raddr = ptr_r;
    if (state_r == ST_CLEAR) begin
      mem_we = 1'b1;
    end else if (evict) begin
      mem_we    = 1'b1;
      mem_waddr = rd_addr_r;
      mem_wdata = '{resident: 1'b0, stamp: mem_rdata_r.stamp};
    end else if (state_r == ST_ACC_WR) begin
      mem_we    = 1'b1;
      mem_waddr = acc_addr;
      mem_wdata = '{resident: 1'b1, stamp: now_r};
    end
    if (state_r == ST_ACC_RD) begin
      mem_raddr = acc_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r          <= ST_CLEAR;
      entry_count_r    <= aee_pkg::ENTRY_COUNT_RST;
      max_idle_r       <= aee_pkg::MAX_IDLE_RST;
      sweep_interval_r <= aee_pkg::SWEEP_INTERVAL_RST;
      last_sweep_r     <= '0;
      ptr_r            <= '0;
      rd_vld_r         <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          aee_pkg::CFG_ENTRY_COUNT:    entry_count_r    <= cfg_data[aee_pkg::COUNT_W-1:0];
          aee_pkg::CFG_MAX_IDLE:       max_idle_r       <= cfg_data;
          aee_pkg::CFG_SWEEP_INTERVAL: sweep_interval_r <= cfg_data;
          default: ;
        endcase
      end

      if ((state_r == ST_EMIT) && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      rd_vld_r  <= (state_r == ST_SWEEP);
      rd_addr_r <= ptr_r;

      if (evict && (cnt_r != '1)) begin
        cnt_r <= cnt_r + aee_pkg::COUNT_W'(1);
      end

      case (state_r)
        ST_CLEAR: begin
          if (LIM_W'(ptr_r) == LIM_W'(MAX_ENTRIES - 1)) begin
            ptr_r   <= '0;
            state_r <= ST_IDLE;
          end else begin
            ptr_r <= ptr_r + IDX_W'(1);
          end
        end
        ST_IDLE: begin
          if (in_acc) begin
            idx_r   <= in_entry_index;
            now_r   <= in_now_ms;
            swept_r <= 1'b0;
            cnt_r   <= '0;
            ptr_r   <= '0;
            if (reject) begin
              status_r <= aee_pkg::STATUS_REJECT;
              state_r  <= ST_EMIT;
            end else if (due) begin
              last_sweep_r <= in_now_ms;
              swept_r      <= 1'b1;
              state_r      <= ST_SWEEP;
            end else begin
              state_r <= ST_ACC_RD;
            end
          end
        end
        ST_SWEEP: begin
          if (LIM_W'(ptr_r) == lim - LIM_W'(1)) begin
            state_r <= ST_SWEEP_END;
          end else begin
            ptr_r <= ptr_r + IDX_W'(1);
          end
        end
        ST_SWEEP_END: begin
          state_r <= ST_ACC_RD;
        end
        ST_ACC_RD: begin
          state_r <= ST_ACC_WR;
        end
        ST_ACC_WR: begin
          status_r <= mem_rdata_r.resident ? aee_pkg::STATUS_HIT : aee_pkg::STATUS_MISS;
          state_r  <= ST_EMIT;
        end
        ST_EMIT: begin
          if (out_free) begin
            out_status_r <= status_r;
            out_swept_r  <= swept_r;
            out_cnt_r    <= cnt_r;
            state_r      <= ST_IDLE;
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_EMIT))
    else $error("result appeared outside emit");

  a_no_sweep_no_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_swept |-> out_evicted_count == '0)
    else $error("evictions reported without a sweep");

  a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == aee_pkg::STATUS_REJECT |-> !out_swept)
    else $error("rejected request ran a sweep");

  a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_IDLE |-> !mem_we)
    else $error("entry memory written while idle");

endmodule

// ===== bench/access_result_checker.sv =====
`timescale 1ns / 1ps
module access_result_checker #(
  parameter int MAX_ENTRIES = aee_pkg::MAX_ENTRIES_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic [aee_pkg::INDEX_W-1:0]    in_entry_index,
  input  logic [aee_pkg::TIME_W-1:0]     in_now_ms,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic [aee_pkg::STATUS_W-1:0]   out_status,
  input  logic                           out_swept,
  input  logic [aee_pkg::COUNT_W-1:0]    out_evicted_count,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [aee_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [aee_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                             mismatch_count,
  output int                             open_reqs
);
  import aee_pkg::*;

  localparam logic [COUNT_W-1:0] COUNT_SAT = '1;

  typedef struct packed {
    logic [INDEX_W-1:0]  entry_index;
    logic [TIME_W-1:0]   now_ms;
    logic [STATUS_W-1:0] status;
    logic                swept;
    logic [COUNT_W-1:0]  evicted_count;
  } access_result_t;

  logic [COUNT_W-1:0] entry_limit;
  logic [TIME_W-1:0]  max_idle;
  logic [TIME_W-1:0]  sweep_interval;
  logic               resident [MAX_ENTRIES];
  logic [TIME_W-1:0]  stamp [MAX_ENTRIES];
  logic [TIME_W-1:0]  last_sweep;

  access_result_t expected_results [$];
  access_result_t head;

  function automatic access_result_t predict_access(input logic [INDEX_W-1:0] idx,
                                                    input logic [TIME_W-1:0] now);
    access_result_t r;
    int limit;
    logic [TIME_W-1:0] age;
    r.entry_index = idx;
    r.now_ms = now;
    r.status = STATUS_REJECT;
    r.swept = 1'b0;
    r.evicted_count = '0;
    limit = (int'(entry_limit) > MAX_ENTRIES) ? MAX_ENTRIES : int'(entry_limit);
    if (int'(idx) >= limit) return r;
    age = now - last_sweep;
    if (age > sweep_interval) begin
      last_sweep = now;
      r.swept = 1'b1;
      for (int i = 0; i < limit; i++) begin
        age = now - stamp[i];
        if (resident[i] && age > max_idle) begin
          resident[i] = 1'b0;
          if (r.evicted_count != COUNT_SAT) r.evicted_count++;
        end
      end
    end
    r.status = resident[idx] ? STATUS_HIT : STATUS_MISS;
    resident[idx] = 1'b1;
    stamp[idx] = now;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      entry_limit = ENTRY_COUNT_RST;
      max_idle = MAX_IDLE_RST;
      sweep_interval = SWEEP_INTERVAL_RST;
      last_sweep = '0;
      for (int i = 0; i < MAX_ENTRIES; i++) begin
        resident[i] = 1'b0;
        stamp[i] = '0;
      end
      expected_results.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_ENTRY_COUNT:    entry_limit = cfg_data[COUNT_W-1:0];
          CFG_MAX_IDLE:       max_idle = cfg_data;
          CFG_SWEEP_INTERVAL: sweep_interval = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          if (mismatch_count < 10)
            $display("unexpected result: status %0d swept %0d evicted %0d",
                     out_status, out_swept, out_evicted_count);
          mismatch_count++;
        end else begin
          head = expected_results.pop_front();
          if (out_status !== head.status || out_swept !== head.swept ||
              out_evicted_count !== head.evicted_count) begin
            if (mismatch_count < 10)
              $display("mismatch on request idx %0d now %0d: expected %0d/%0d/%0d got %0d/%0d/%0d",
                       head.entry_index, head.now_ms, head.status, head.swept,
                       head.evicted_count, out_status, out_swept, out_evicted_count);
            mismatch_count++;
          end
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_access(in_entry_index, in_now_ms));
    end
    open_reqs <= expected_results.size();
  end

endmodule

// ===== bench/tb.sv =====
`timescale 1ns / 1ps
module tb;
  import aee_pkg::*;

  localparam int MAX_ENTRIES = MAX_ENTRIES_DEF;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  logic [INDEX_W-1:0]    in_entry_index;
  logic [TIME_W-1:0]     in_now_ms;
  logic                  out_valid;
  logic                  out_stall;
  logic [STATUS_W-1:0]   out_status;
  logic                  out_swept;
  logic [COUNT_W-1:0]    out_evicted_count;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int          mismatches;
  int          open_reqs;
  logic [31:0] t_now;
  int          burst_left;
  logic        hold_go;

  always #5 clk = ~clk;

  age_based_entry_eviction_unit #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) DUT (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_entry_index(in_entry_index),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_swept(out_swept),
    .out_evicted_count(out_evicted_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  access_result_checker #(
    .MAX_ENTRIES(MAX_ENTRIES)
  ) results_check (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_entry_index(in_entry_index),
    .in_now_ms(in_now_ms),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_status(out_status),
    .out_swept(out_swept),
    .out_evicted_count(out_evicted_count),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatches),
    .open_reqs(open_reqs)
  );

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (open_reqs != 0) @(posedge clk);
  endtask

  task automatic issue(input logic [INDEX_W-1:0] idx, input logic [TIME_W-1:0] t);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 7);
      burst_left = $urandom_range(1, 24);
      if (gap != 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    in_valid <= 1'b1;
    in_entry_index <= idx;
    in_now_ms <= t;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic run_phase(input logic [31:0] cnt, input logic [31:0] idle,
                           input logic [31:0] ivl, input int scale, input int n);
    int lim;
    int r;
    logic [INDEX_W-1:0] idx;
    drain();
    cfg_write(CFG_ENTRY_COUNT, cnt);
    cfg_write(CFG_MAX_IDLE, idle);
    cfg_write(CFG_SWEEP_INTERVAL, ivl);
    cfg_valid <= 1'b0;
    lim = (int'(cnt[COUNT_W-1:0]) > MAX_ENTRIES) ? MAX_ENTRIES : int'(cnt[COUNT_W-1:0]);
    repeat (n) begin
      r = $urandom_range(0, 19);
      // occasional jump anywhere on the wrapping clock, sometimes a repeated time
      if (r == 0) t_now = $urandom;
      else if (r > 1) t_now += $urandom_range(0, scale);
      if (lim == 0 || $urandom_range(0, 6) == 0) idx = INDEX_W'($urandom_range(0, 1023));
      else idx = INDEX_W'($urandom_range(0, lim - 1));
      issue(idx, t_now);
    end
  endtask

  initial begin
    int n_rand;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_entry_index = '0;
    in_now_ms = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_ENTRY_COUNT;
    cfg_data = '0;
    t_now = '0;
    burst_left = 0;
    hold_go = 1'b0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // no entries in use after reset
    issue(10'd0, 32'd0);
    issue(10'd1023, 32'hFFFF_FFFF);

    // reset idle and sweep times, full table
    drain();
    cfg_write(CFG_ENTRY_COUNT, 32'd1024);
    cfg_write(CFG_UNUSED, 32'h0000_0005);
    cfg_valid <= 1'b0;
    issue(10'd0, 32'd5000);
    issue(10'd0, 32'd6000);
    issue(10'd1023, 32'd10000);
    issue(10'd1, 32'd10001);
    issue(10'd2, 32'd310001);
    issue(10'd0, 32'd310002);
    issue(10'd7, 32'hFFFF_FFF0);
    issue(10'd8, 32'h0000_0010);
    issue(10'd7, 32'h0000_2720);
    issue(10'd1023, 32'h0000_2721);

    // zero idle time and zero interval
    drain();
    cfg_write(CFG_MAX_IDLE, 32'd0);
    cfg_write(CFG_SWEEP_INTERVAL, 32'd0);
    cfg_valid <= 1'b0;
    issue(10'd3, 32'd100);
    issue(10'd3, 32'd100);
    issue(10'd4, 32'd101);
    issue(10'd3, 32'd102);

    // nothing ever ages out, sweeps never due
    drain();
    cfg_write(CFG_MAX_IDLE, 32'hFFFF_FFFF);
    cfg_write(CFG_SWEEP_INTERVAL, 32'hFFFF_FFFF);
    cfg_valid <= 1'b0;
    issue(10'd5, 32'd0);
    issue(10'd5, 32'd12345);
    issue(10'd1022, 32'h8000_0000);

    hold_go <= 1'b1;
    t_now = 32'd1000;
    run_phase(32'd16, 32'd300, 32'd100, 60, 120);
    run_phase(32'd40, 32'd2000, 32'd0, 150, 90);
    run_phase(32'd1024, 32'd4000, 32'd2500, 400, 60);
    run_phase(32'd2047, 32'd0, 32'd0, 3, 20);
    // shrink below the populated range, then grow again
    run_phase(32'd8, 32'hFFFF_FFFF, 32'd50, 40, 60);
    run_phase(32'd200, 32'd1000, 32'd500, 100, 90);
    run_phase(32'd32, 32'd500, 32'hFFFF_FFFF, 100, 20);
    repeat (3) begin
      n_rand = $urandom_range(1, 64);
      run_phase(n_rand, $urandom_range(50, 3000), $urandom_range(0, 1500),
                $urandom_range(20, 400), 40);
    end

    drain();
    repeat (MAX_ENTRIES + 8) @(posedge clk);
    if (mismatches == 0 && open_reqs == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  // result side backpressure, with one long hold-off once random traffic starts
  initial begin
    int seg;
    int mode;
    logic held;
    held = 1'b0;
    out_stall = 1'b0;
    forever begin
      if (hold_go && !held) begin
        held = 1'b1;
        repeat (400) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end
      seg = $urandom_range(1, 40);
      mode = $urandom_range(0, 3);
      repeat (seg) begin
        @(posedge clk);
        case (mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 2) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  initial begin
    #(30_000_000);
    $display("TB_ERROR");
    $finish;
  end

endmodule
